// ===== rtl/core/frame_window_multiplier_defines.svh =====
// Assertion macros shared by the frame window multiplier RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef FRAME_WINDOW_MULTIPLIER_DEFINES_SVH
`define FRAME_WINDOW_MULTIPLIER_DEFINES_SVH

// same-cycle implication
`define FWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fwm_pkg.sv =====
// Shared types and constants of the frame window multiplier.
// No dependencies; used by fwm_ctrl, fwm_datapath and the top level.
package fwm_pkg;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_WINDOW_KIND  = 2'd1;
	localparam logic [1:0] REG_SYMMETRIC    = 2'd2;

	// window kinds
	localparam logic [1:0] KIND_HANN      = 2'd0;
	localparam logic [1:0] KIND_HAMMING   = 2'd1;
	localparam logic [1:0] KIND_HALF_HANN = 2'd2;

	// register reset values
	localparam logic [12:0] FRAME_LENGTH_RST = 13'd256;
	localparam logic [1:0]  WINDOW_KIND_RST  = 2'd0;
	localparam logic        SYMMETRIC_RST    = 1'b1;

	// phase divider: one integer bit plus 32 fraction bits, one per cycle
	localparam int          DIV_BITS = 33;
	localparam logic [5:0]  DIV_LAST = 6'(DIV_BITS - 1);

	// CORDIC constants, Q1.30
	localparam int                 XW       = 34;
	localparam int                 ZW       = 33;
	localparam logic signed [XW-1:0] GAIN_Q30 = 34'sh026DD3B6A;
	localparam logic [29:0]        HALF_Q30 = 30'd536870912;
	localparam logic [29:0]        C054_Q30 = 30'd579820585;
	localparam logic [29:0]        C046_Q30 = 30'd493921239;
	localparam int                 ATAN_N   = 24;

	localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// arctangent of 2^-i as a fraction of a turn
	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] v;
		v = 32'd0;
		if (i < 5'(ATAN_N)) begin
			v = ATAN_TURN[i];
		end
		return v;
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_step;
		logic rot_init;
		logic rot_step;
		logic mul_b;
		logic coef;
		logic scale;
		logic out_load;
	} fwm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_last;
		logic rot_last;
		logic out_free;
	} fwm_sts_t;

	// controller states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_DIV   = 8'b00000010,
		ST_RINIT = 8'b00000100,
		ST_ROT   = 8'b00001000,
		ST_MULB  = 8'b00010000,
		ST_COEF  = 8'b00100000,
		ST_SCALE = 8'b01000000,
		ST_OUT   = 8'b10000000
	} fwm_state_t;

endpackage

// ===== rtl/core/fwm_ctrl.sv =====
// Sequencing state machine of the frame window multiplier.
// Depends on fwm_pkg; drives fwm_datapath through fwm_cmd_t.
module fwm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fwm_pkg::fwm_sts_t sts,
	output fwm_pkg::fwm_cmd_t cmd
);

	fwm_pkg::fwm_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = fwm_pkg::ST_DIV;
				end
			end
			fwm_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = fwm_pkg::ST_RINIT;
			end
			fwm_pkg::ST_RINIT: begin
				cmd.rot_init = 1'b1;
				state_d      = fwm_pkg::ST_ROT;
			end
			fwm_pkg::ST_ROT: begin
				cmd.rot_step = 1'b1;
				if (sts.rot_last) state_d = fwm_pkg::ST_MULB;
			end
			fwm_pkg::ST_MULB: begin
				cmd.mul_b = 1'b1;
				state_d   = fwm_pkg::ST_COEF;
			end
			fwm_pkg::ST_COEF: begin
				cmd.coef = 1'b1;
				state_d  = fwm_pkg::ST_SCALE;
			end
			fwm_pkg::ST_SCALE: begin
				// sample x coefficient
				cmd.scale = 1'b1;
				state_d   = fwm_pkg::ST_OUT;
			end
			fwm_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = fwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fwm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/fwm_datapath.sv =====
// Datapath: frame index, phase divider, CORDIC cosine, coefficient and scaling.
// Depends on fwm_pkg; sequenced by fwm_ctrl.
module fwm_datapath #(
	parameter int MAX_LENGTH   = 4096,
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16,
	parameter int LW           = $clog2(MAX_LENGTH + 1),
	parameter int IW           = $clog2(MAX_LENGTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fwm_pkg::fwm_cmd_t       cmd,
	output fwm_pkg::fwm_sts_t       sts,
	input  logic [LW-1:0]           len,
	input  logic [1:0]              kind,
	input  logic                    sym,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	input  logic                    eof,
	output logic [SAMPLE_WIDTH-1:0] windowed_sample,
	output logic                    last_of_frame,
	output logic                    size_error,
	output logic                    out_valid,
	input  logic                    out_ready
);

	localparam int KW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int RW  = LW + 1;
	localparam int PW  = 31 + fwm_pkg::XW;
	localparam int AW  = PW + 1;
	localparam int MW  = SAMPLE_WIDTH + 17;
	localparam int SW2 = MW + 1;
	localparam logic signed [SW2-1:0] SAT_HI = SW2'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW2-1:0] SAT_LO = -SAT_HI - SW2'(1);

	// control registers
	logic [IW-1:0] idx_q;
	logic [5:0]    div_cnt_q;
	logic [KW-1:0] k_q;
	logic          out_valid_q;

	// payload registers
	logic signed [SAMPLE_WIDTH-1:0] s_q;
	logic                           last_q, err_q;
	logic [LW-1:0]                  n_q;
	logic [RW-1:0]                  rem_q;
	logic [fwm_pkg::DIV_BITS-1:0]   quo_q;
	logic signed [fwm_pkg::XW-1:0]  x_q, y_q;
	logic signed [fwm_pkg::ZW-1:0]  z_q;
	logic [1:0]                     quad_q;
	logic signed [PW-1:0]           prod_q;
	logic [15:0]                    coef_q;
	logic signed [MW-1:0]           scl_q;
	logic [SAMPLE_WIDTH-1:0]        ws_q;
	logic                           lof_q, serr_q;

	// frame position for the accepted word
	logic [LW-1:0] lenm1, idx_ext;
	logic          at_end, close;
	logic [IW-1:0] pos;
	always_comb begin
		lenm1   = len - LW'(1);
		idx_ext = LW'(idx_q);
		at_end  = idx_ext >= lenm1;
		pos     = at_end ? lenm1[IW-1:0] : idx_q;
		close   = eof | at_end;
	end

	// one restoring division bit; first step has no doubling
	logic [RW-1:0] dtrial;
	logic          dbit;
	always_comb begin
		dtrial = (div_cnt_q == 6'd0) ? rem_q : {rem_q[RW-2:0], 1'b0};
		dbit   = dtrial >= RW'(n_q);
	end

	// turn fraction; half Hann covers half a turn
	logic [31:0] turn;
	assign turn = (kind == fwm_pkg::KIND_HALF_HANN) ? quo_q[32:1] : quo_q[31:0];

	// one CORDIC rotation
	logic signed [fwm_pkg::XW-1:0] dx, dy;
	logic signed [fwm_pkg::ZW-1:0] at;
	always_comb begin
		dx = y_q >>> k_q;
		dy = x_q >>> k_q;
		at = $signed({1'b0, fwm_pkg::atan_at(5'(k_q))});
	end

	// quadrant unfold and window slope
	logic signed [fwm_pkg::XW-1:0] cosv;
	logic [29:0]                   bmag;
	always_comb begin
		unique case (quad_q)
			2'd0:    cosv = x_q;
			2'd1:    cosv = -y_q;
			2'd2:    cosv = -x_q;
			default: cosv = y_q;
		endcase
		bmag = (kind == fwm_pkg::KIND_HAMMING) ? fwm_pkg::C046_Q30 : fwm_pkg::HALF_Q30;
	end

	// coefficient: offset +- slope*cos, clamped to [0, 1.0], rounded to Q1.15
	logic [29:0]          aoff;
	logic signed [AW-1:0] a_sh, acc;
	logic [AW-1:0]        acc_c, acc_r;
	always_comb begin
		aoff = (kind == fwm_pkg::KIND_HAMMING) ? fwm_pkg::C054_Q30 : fwm_pkg::HALF_Q30;
		a_sh = $signed(AW'({aoff, 30'd0}));
		acc  = (kind == fwm_pkg::KIND_HALF_HANN) ? a_sh + AW'(prod_q) : a_sh - AW'(prod_q);
		if (acc[AW-1]) begin
			acc_c = '0;
		end else if (acc > $signed(AW'(1) <<< 60)) begin
			acc_c = AW'(1) << 60;
		end else begin
			acc_c = AW'(acc);
		end
		acc_r = acc_c + (AW'(1) << 44);
	end

	// product rounding and saturation
	logic signed [SW2-1:0] rnd, shv;
	logic [SAMPLE_WIDTH-1:0] sat;
	always_comb begin
		rnd = SW2'(scl_q) + SW2'(16384);
		shv = rnd >>> 15;
		if (shv > SAT_HI) begin
			sat = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (shv < SAT_LO) begin
			sat = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			sat = shv[SAMPLE_WIDTH-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			div_cnt_q   <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q     <= close ? '0 : idx_q + IW'(1);
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			if (cmd.rot_init) begin
				k_q <= '0;
			end else if (cmd.rot_step) begin
				k_q <= k_q + KW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q    <= $signed(sample);
			last_q <= close;
			err_q  <= close & ~(eof & (idx_ext == lenm1));
			n_q    <= sym ? lenm1 : len;
			rem_q  <= RW'(pos);
		end
		if (cmd.div_step) begin
			rem_q <= dbit ? dtrial - RW'(n_q) : dtrial;
			quo_q <= {quo_q[fwm_pkg::DIV_BITS-2:0], dbit};
		end
		if (cmd.rot_init) begin
			x_q    <= fwm_pkg::GAIN_Q30;
			y_q    <= '0;
			z_q    <= $signed({3'b000, turn[29:0]});
			quad_q <= turn[31:30];
		end else if (cmd.rot_step) begin
			if (!z_q[fwm_pkg::ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (cmd.mul_b) begin
			prod_q <= $signed({1'b0, bmag}) * cosv;
		end
		if (cmd.coef) begin
			coef_q <= acc_r[60:45];
		end
		if (cmd.scale) begin
			scl_q <= s_q * $signed({1'b0, coef_q});
		end
		if (cmd.out_load) begin
			ws_q   <= sat;
			lof_q  <= last_q;
			serr_q <= err_q;
		end
	end

	assign sts.div_last   = div_cnt_q == fwm_pkg::DIV_LAST;
	assign sts.rot_last   = k_q == KW'(CORDIC_STEPS - 1);
	assign sts.out_free   = ~out_valid_q | out_ready;
	assign out_valid       = out_valid_q;
	assign windowed_sample = ws_q;
	assign last_of_frame   = lof_q;
	assign size_error      = serr_q;

endmodule

// ===== rtl/core/frame_window_multiplier.sv =====
// Top level of the frame window multiplier: register port, controller, datapath.
// Depends on fwm_pkg, fwm_ctrl, fwm_datapath and frame_window_multiplier_defines.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  s_*     | in        | s_tvalid / s_tready     | sample, end_of_frame (s_tlast)
//  m_*     | out       | m_tvalid / m_tready     | windowed_sample, last, size_error
//  apb     | in        | psel & penable, pready  | frame_length, window_kind, symmetric
//
// One word at a time: each word runs through the bit-serial phase divider and the
// CORDIC loop of one rotation per cycle, then the slope multiply, the coefficient
// and the scaling before its result is loaded; s_tready rises together with m_tvalid,
// so no new word is taken while the last one is still in flight.
// A finished result waits in the output register while the next word is taken;
// the next result stalls until that register is free.
// Reset: index 0, registers to 256 / Hann / symmetric, output empty.
`include "frame_window_multiplier_defines.svh"

module frame_window_multiplier #(
	parameter int MAX_LENGTH   = 4096,
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// sample (bits SAMPLE_WIDTH-1:0), zero padding above
	input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tlast,
	// windowed_sample (bits SAMPLE_WIDTH-1:0), zero padding above
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	output logic m_tlast,
	// size_error (bit 0)
	output logic m_tuser,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int IW = $clog2(MAX_LENGTH);
	localparam int CW = (LW > 13) ? LW : 13;
	localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

	logic [12:0] frame_length_q;
	logic [1:0]  window_kind_q;
	logic        symmetric_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= fwm_pkg::FRAME_LENGTH_RST;
			window_kind_q  <= fwm_pkg::WINDOW_KIND_RST;
			symmetric_q    <= fwm_pkg::SYMMETRIC_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				fwm_pkg::REG_FRAME_LENGTH: frame_length_q <= pwdata[12:0];
				fwm_pkg::REG_WINDOW_KIND:  window_kind_q  <= pwdata[1:0];
				fwm_pkg::REG_SYMMETRIC:    symmetric_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			fwm_pkg::REG_FRAME_LENGTH: prdata = 32'(frame_length_q);
			fwm_pkg::REG_WINDOW_KIND:  prdata = 32'(window_kind_q);
			fwm_pkg::REG_SYMMETRIC:    prdata = 32'(symmetric_q);
			default:                   prdata = 32'd0;
		endcase
	end

	// frame length in use, clamped to [2, MAX_LENGTH]
	logic [CW-1:0] fl_ext;
	logic [LW-1:0] len;
	always_comb begin
		fl_ext = CW'(frame_length_q);
		if (fl_ext < CW'(2)) begin
			len = LW'(2);
		end else if (fl_ext > CW'(MAX_LENGTH)) begin
			len = LW'(MAX_LENGTH);
		end else begin
			len = LW'(fl_ext);
		end
	end

	fwm_pkg::fwm_cmd_t cmd;
	fwm_pkg::fwm_sts_t sts;
	logic [SAMPLE_WIDTH-1:0] ws;

	fwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fwm_datapath #(
		.MAX_LENGTH   (MAX_LENGTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS),
		.LW           (LW),
		.IW           (IW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.len             (len),
		.kind            (window_kind_q),
		.sym             (symmetric_q),
		.sample          (s_tdata[SAMPLE_WIDTH-1:0]),
		.eof             (s_tlast),
		.windowed_sample (ws),
		.last_of_frame   (m_tlast),
		.size_error      (m_tuser),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready)
	);

	assign m_tdata = DW'(ws);

	// checks
	`FWM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "word accepted while busy")
	`FWM_ASSERT_NOW(a_out_slot_free, cmd.out_load, !m_tvalid || m_tready, "result overwrote a held word")
	`FWM_ASSERT_NOW(a_err_on_last, m_tvalid && !m_tlast, !m_tuser, "size error off a frame end")

endmodule

// ===== test/frame_window_multiplier_tb.sv =====
// Self-checking testbench for frame_window_multiplier: window kinds, frame ends, size errors.
// Depends on fwm_pkg and the frame_window_multiplier RTL; predicts words in plain SV or takes a typed result.
module frame_window_multiplier_tb;
	import fwm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STEPS = 16;

	logic clk;
	logic arst_n;
	logic [15:0] s_tdata;
	logic s_tvalid;
	logic s_tready;
	logic s_tlast;
	logic [15:0] m_tdata;
	logic m_tvalid;
	logic m_tready;
	logic m_tlast;
	logic m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	frame_window_multiplier dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	// one windowed word: data, last, size error
	typedef struct {
		logic [15:0] data;
		logic last;
		logic err;
	} win_word_t;

	// directed stimulus row: a register write or a word, optionally with a typed result
	typedef struct {
		bit is_cfg;
		logic [1:0] reg_idx;
		logic [31:0] value;
		logic [15:0] smp;
		bit eof;
		bit typed;
		win_word_t want;
	} stim_row_t;

	win_word_t pending_q[$];
	stim_row_t stim_tbl[$];
	int fail_cnt;
	int words_sent;
	bit quiet;
	bit hold_req;
	int hold_left;
	int stall_left;

	// predictor copy of registers and frame position
	logic [12:0] cur_len;
	logic [1:0] cur_kind;
	logic cur_sym;
	logic [11:0] frame_pos;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("frame_window_multiplier_tb: FAIL");
		$finish;
	end

	// CORDIC cosine of a turn fraction, Q1.30
	function automatic longint cos_of_turn(input logic [31:0] turn);
		longint x, y, z, dx, dy;
		x = 64'sd652032874;
		y = 0;
		z = longint'(turn[29:0]);
		for (int k = 0; k < STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURN[k]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURN[k]);
			end
		end
		case (turn[31:30])
			2'd0: return x;
			2'd1: return -y;
			2'd2: return -x;
			default: return y;
		endcase
	endfunction

	// window coefficient in 2^-15 units at a position
	function automatic longint coef_at(input longint pos, input longint len);
		longint unsigned n, num;
		logic [31:0] turn;
		longint a, b, acc;
		n = cur_sym ? len - 1 : len;
		num = (cur_kind == KIND_HALF_HANN) ? (pos << 31) : (pos << 32);
		turn = 32'(num / n);
		if (cur_kind == KIND_HAMMING) begin
			a = longint'(C054_Q30); b = -longint'(C046_Q30);
		end else if (cur_kind == KIND_HALF_HANN) begin
			a = longint'(HALF_Q30); b = longint'(HALF_Q30);
		end else begin
			a = longint'(HALF_Q30); b = -longint'(HALF_Q30);
		end
		acc = a * (64'sd1 <<< 30) + b * cos_of_turn(turn);
		if (acc < 0) acc = 0;
		if (acc > (64'sd1 <<< 60)) acc = 64'sd1 <<< 60;
		return (acc + (64'sd1 <<< 44)) >>> 45;
	endfunction

	// windowed result of one accepted word, advances the frame position
	function automatic win_word_t window_word(input logic [15:0] smp, input bit eof);
		win_word_t r;
		longint len, pos, p;
		bit at_end;
		len = cur_len < 2 ? 2 : (cur_len > 4096 ? 4096 : cur_len);
		pos = frame_pos;
		at_end = pos >= len - 1;
		if (at_end) pos = len - 1;
		p = (longint'($signed(smp)) * coef_at(pos, len) + 64'sd16384) >>> 15;
		if (p < -32768) p = -32768;
		if (p > 32767) p = 32767;
		r.data = p[15:0];
		if (eof || at_end) begin
			r.last = 1'b1;
			r.err = !(eof && frame_pos == len - 1);
			frame_pos = '0;
		end else begin
			r.last = 1'b0;
			r.err = 1'b0;
			frame_pos = frame_pos + 12'd1;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_cnt++;
	endtask

	// write one register once every word is back and the block has settled
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_FRAME_LENGTH: cur_len = value[12:0];
			REG_WINDOW_KIND: cur_kind = value[1:0];
			REG_SYMMETRIC: cur_sym = value[0];
			default: ;
		endcase
	endtask

	// offer one word, hold until accepted, then maybe idle a burst
	task automatic send_word(input logic [15:0] smp, input bit eof,
			input bit typed, input win_word_t want);
		win_word_t pred;
		s_tdata <= smp; s_tlast <= eof; s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = window_word(smp, eof);
		pending_q.push_back(typed ? want : pred);
		words_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] value);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1; r.reg_idx = idx; r.value = value;
		stim_tbl.push_back(r);
	endfunction

	function automatic void add_word(input logic [15:0] smp, input bit eof, input bit typed,
			input logic [15:0] w, input bit l, input bit e);
		stim_row_t r;
		r = '{default: '0};
		r.smp = smp; r.eof = eof; r.typed = typed;
		r.want.data = w; r.want.last = l; r.want.err = e;
		stim_tbl.push_back(r);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// output check against the oldest expected word
	always @(posedge clk) begin
		win_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report("unexpected word", 32'(m_tdata), 32'd0);
			end else begin
				exp_w = pending_q.pop_front();
				if (m_tdata !== exp_w.data)
					report("windowed_sample", 32'(m_tdata), 32'(exp_w.data));
				if (m_tlast !== exp_w.last)
					report("last_of_frame", 32'(m_tlast), 32'(exp_w.last));
				if (m_tuser !== exp_w.err)
					report("size_error", 32'(m_tuser), 32'(exp_w.err));
			end
		end
	end

	// receiver: long hold on request, random stall bursts otherwise
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
		end
	end

	initial begin
		win_word_t none;
		int len_sel, nframes, fsize, ftype, phase;
		logic [31:0] len_val;
		none = '{default: '0};
		fail_cnt = 0; words_sent = 0; quiet = 0; hold_req = 0;
		hold_left = 0; stall_left = 0;
		cur_len = FRAME_LENGTH_RST; cur_kind = WINDOW_KIND_RST; cur_sym = SYMMETRIC_RST;
		frame_pos = '0;
		arst_n = 1'b0;
		s_tdata = '0; s_tvalid = 1'b0; s_tlast = 1'b0; m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: after reset, exact and odd frame ends, each kind, clamps
		add_word(16'h7FFF, 0, 1, 16'h0000, 0, 0);
		add_word(16'h8000, 1, 0, 0, 0, 0);
		add_cfg(REG_FRAME_LENGTH, 4);
		add_word(16'h7FFF, 0, 1, 16'h0000, 0, 0);
		add_word(16'h8000, 0, 0, 0, 0, 0);
		add_word(16'h7FFF, 0, 0, 0, 0, 0);
		add_word(16'h8000, 1, 1, 16'h0000, 1, 0);
		add_word(16'h1234, 0, 0, 0, 0, 0);
		add_word(16'h1234, 0, 0, 0, 0, 0);
		add_word(16'h1234, 0, 0, 0, 0, 0);
		add_word(16'h5555, 0, 1, 16'h0000, 1, 1);
		add_word(16'h4321, 0, 0, 0, 0, 0);
		add_word(16'h7FFF, 1, 0, 0, 0, 0);
		add_cfg(REG_WINDOW_KIND, 32'(KIND_HAMMING));
		add_word(16'h7FFF, 0, 0, 0, 0, 0);
		add_word(16'h8000, 0, 0, 0, 0, 0);
		add_word(16'h0001, 1, 0, 0, 0, 0);
		add_cfg(REG_WINDOW_KIND, 32'(KIND_HALF_HANN));
		add_word(16'h7FFF, 0, 0, 0, 0, 0);
		add_word(16'h8000, 0, 0, 0, 0, 0);
		add_word(16'hFFFF, 0, 0, 0, 0, 0);
		add_word(16'h7FFF, 1, 0, 0, 0, 0);
		add_cfg(REG_WINDOW_KIND, 32'(KIND_UNUSED));
		add_word(16'h7FFF, 0, 1, 16'h0000, 0, 0);
		add_cfg(REG_SYMMETRIC, 0);
		add_word(16'h8000, 1, 0, 0, 0, 0);
		add_cfg(REG_FRAME_LENGTH, 0);
		add_word(16'h7FFF, 0, 0, 0, 0, 0);
		add_word(16'h8000, 0, 0, 0, 0, 0);
		add_cfg(REG_FRAME_LENGTH, 12);
		for (int i = 0; i < 6; i++) add_word(16'h2000, 0, 0, 0, 0, 0);
		// shrink below the current position
		add_cfg(REG_FRAME_LENGTH, 4);
		add_word(16'h7FFF, 0, 0, 0, 0, 0);
		add_cfg(REG_FRAME_LENGTH, 8191);
		add_word(16'h7FFF, 0, 0, 0, 0, 0);
		add_word(16'h8000, 1, 0, 0, 0, 0);

		foreach (stim_tbl[i]) begin
			if (stim_tbl[i].is_cfg) begin
				s_tvalid <= 1'b0;
				write_reg(stim_tbl[i].reg_idx, stim_tbl[i].value);
			end else begin
				send_word(stim_tbl[i].smp, stim_tbl[i].eof, stim_tbl[i].typed, stim_tbl[i].want);
			end
		end

		// random phases of mostly well-formed frames
		phase = 0;
		while (words_sent < 420) begin
			s_tvalid <= 1'b0;
			len_sel = $urandom_range(0, 19);
			if (len_sel < 17) len_val = $urandom_range(2, 16);
			else if (len_sel == 17) len_val = $urandom_range(0, 1);
			else if (len_sel == 18) len_val = ($urandom_range(0, 1) != 0) ? 4096 : 8191;
			else len_val = $urandom_range(17, 300);
			write_reg(REG_FRAME_LENGTH, len_val);
			write_reg(REG_WINDOW_KIND, $urandom_range(0, 3));
			write_reg(REG_SYMMETRIC, $urandom_range(0, 1));
			if (phase == 4) hold_req = 1;
			if (words_sent > 360) quiet = 1;
			nframes = $urandom_range(1, 4);
			for (int f = 0; f < nframes; f++) begin
				fsize = (cur_len < 2) ? 2 : cur_len;
				ftype = $urandom_range(0, 9);
				if (fsize > 16) begin
					fsize = $urandom_range(1, 20);
					for (int i = 0; i < fsize; i++) send_word(rand_sample(), i == fsize - 1, 0, none);
				end else if (ftype < 7) begin
					for (int i = 0; i < fsize; i++) send_word(rand_sample(), i == fsize - 1, 0, none);
				end else if (ftype == 7) begin
					fsize = $urandom_range(1, fsize - 1);
					for (int i = 0; i < fsize; i++) send_word(rand_sample(), i == fsize - 1, 0, none);
				end else if (ftype == 8) begin
					for (int i = 0; i < fsize; i++) send_word(rand_sample(), 0, 0, none);
				end else begin
					fsize = $urandom_range(1, fsize + 2);
					for (int i = 0; i < fsize; i++)
						send_word(rand_sample(), $urandom_range(0, 3) == 0, 0, none);
				end
			end
			// pause the sender until the block has drained
			if (phase == 8) begin
				s_tvalid <= 1'b0;
				while (pending_q.size() != 0) @(posedge clk);
			end
			phase++;
		end
		s_tvalid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_cnt == 0 && pending_q.size() == 0) begin
			$display("frame_window_multiplier_tb: PASS");
		end else begin
			$display("frame_window_multiplier_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fwm_pkg.sv
rtl/core/fwm_ctrl.sv
rtl/core/fwm_datapath.sv
rtl/core/frame_window_multiplier.sv
test/frame_window_multiplier_tb.sv
